>>> src/miae_pkg.sv
// ----------------------------------------------------------------------------
// miae_pkg
// shared types, opcode codes and helpers for the integer execute unit
// ----------------------------------------------------------------------------
package miae_pkg;

   localparam logic [5:0] OP_SPECIAL  = 6'h00;
   localparam logic [5:0] OP_ADDI     = 6'h08;
   localparam logic [5:0] OP_ADDIU    = 6'h09;
   localparam logic [5:0] OP_SLTI     = 6'h0a;
   localparam logic [5:0] OP_SLTIU    = 6'h0b;
   localparam logic [5:0] OP_ANDI     = 6'h0c;
   localparam logic [5:0] OP_ORI      = 6'h0d;
   localparam logic [5:0] OP_XORI     = 6'h0e;
   localparam logic [5:0] OP_LUI      = 6'h0f;
   localparam logic [5:0] OP_SPECIAL3 = 6'h1f;

   localparam logic [5:0] FN_SLL   = 6'h00;
   localparam logic [5:0] FN_SRL   = 6'h02;
   localparam logic [5:0] FN_SRA   = 6'h03;
   localparam logic [5:0] FN_SLLV  = 6'h04;
   localparam logic [5:0] FN_SRLV  = 6'h06;
   localparam logic [5:0] FN_SRAV  = 6'h07;
   localparam logic [5:0] FN_MOVZ  = 6'h0a;
   localparam logic [5:0] FN_MOVN  = 6'h0b;
   localparam logic [5:0] FN_MFHI  = 6'h10;
   localparam logic [5:0] FN_MTHI  = 6'h11;
   localparam logic [5:0] FN_MFLO  = 6'h12;
   localparam logic [5:0] FN_MTLO  = 6'h13;
   localparam logic [5:0] FN_CLZ   = 6'h16;
   localparam logic [5:0] FN_CLO   = 6'h17;
   localparam logic [5:0] FN_MULT  = 6'h18;
   localparam logic [5:0] FN_MULTU = 6'h19;
   localparam logic [5:0] FN_DIV   = 6'h1a;
   localparam logic [5:0] FN_DIVU  = 6'h1b;
   localparam logic [5:0] FN_MADD  = 6'h1c;
   localparam logic [5:0] FN_MADDU = 6'h1d;
   localparam logic [5:0] FN_ADD   = 6'h20;
   localparam logic [5:0] FN_ADDU  = 6'h21;
   localparam logic [5:0] FN_SUB   = 6'h22;
   localparam logic [5:0] FN_SUBU  = 6'h23;
   localparam logic [5:0] FN_AND   = 6'h24;
   localparam logic [5:0] FN_OR    = 6'h25;
   localparam logic [5:0] FN_XOR   = 6'h26;
   localparam logic [5:0] FN_NOR   = 6'h27;
   localparam logic [5:0] FN_SLT   = 6'h2a;
   localparam logic [5:0] FN_SLTU  = 6'h2b;
   localparam logic [5:0] FN_MAX   = 6'h2c;
   localparam logic [5:0] FN_MIN   = 6'h2d;
   localparam logic [5:0] FN_MSUB  = 6'h2e;
   localparam logic [5:0] FN_MSUBU = 6'h2f;

   // special3 functions and bit-shuffle selectors
   localparam logic [5:0] FN3_EXT   = 6'h00;
   localparam logic [5:0] FN3_INS   = 6'h04;
   localparam logic [5:0] FN3_BSHFL = 6'h20;
   localparam logic [4:0] SEL_WSBH   = 5'd2;
   localparam logic [4:0] SEL_WSBW   = 5'd3;
   localparam logic [4:0] SEL_SEB    = 5'd16;
   localparam logic [4:0] SEL_BITREV = 5'd20;
   localparam logic [4:0] SEL_SEH    = 5'd24;

   // rs or sa field value that turns a right shift into a rotate
   localparam logic [4:0] ROT_SEL = 5'd1;

   // back-end operation classes
   localparam logic [2:0] K_SIMPLE = 3'd0;
   localparam logic [2:0] K_MFHI   = 3'd1;
   localparam logic [2:0] K_MFLO   = 3'd2;
   localparam logic [2:0] K_MTHI   = 3'd3;
   localparam logic [2:0] K_MTLO   = 3'd4;
   localparam logic [2:0] K_MUL    = 3'd5;
   localparam logic [2:0] K_DIV    = 3'd6;

   localparam int QDEPTH = 2;

   typedef struct packed {
      logic [31:0] instruction;
      logic [31:0] rs_value;
      logic [31:0] rt_value;
   } req_type;

   typedef struct packed {
      logic        write_enable;
      logic [4:0]  dest_reg;
      logic [31:0] dest_value;
      logic        unsupported;
      logic [31:0] hi_value;
      logic [31:0] lo_value;
   } rsp_type;

   // classified item handed from front to back
   typedef struct packed {
      logic [2:0]  kind;
      logic        wr;
      logic [4:0]  dst;
      logic [31:0] val;
      logic        bad;
      logic        sgn;   // signed multiply or divide
      logic        acc;   // accumulate
      logic        sub;   // subtract from accumulator
      logic [31:0] a;
      logic [31:0] b;
   } op_type;

   function automatic logic [31:0] rot_r(input logic [31:0] x, input logic [4:0] s);
      rot_r = (x >> s) | (x << (6'd32 - {1'b0, s}));
   endfunction

   function automatic logic [31:0] lead_zeros(input logic [31:0] x);
      logic [5:0] n;
      n = 6'd32;
      for (int i = 0; i < 32; i++) begin
         if (x[i]) n = 6'(31 - i);
      end
      lead_zeros = {26'd0, n};
   endfunction

endpackage

>>> src/miae_if.sv
// ----------------------------------------------------------------------------
// miae_if
// valid/ready channel carrying one payload beat
// ----------------------------------------------------------------------------
interface miae_req_if;
   logic                 valid;
   logic                 ready;
   miae_pkg::req_type    payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface miae_rsp_if;
   logic                 valid;
   logic                 ready;
   miae_pkg::rsp_type    payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> src/mips_integer_alu_execute_core.sv
// ----------------------------------------------------------------------------
// mips_integer_alu_execute_core
// integer execute unit: decode front, two-entry queue, hi/lo back end
// ----------------------------------------------------------------------------
// Every instruction gives exactly one response beat. Plain ALU, shift, bit
// and move operations are answered from the idle state of the back end, so
// the unit sustains one per cycle while responses are taken. Multiply and
// multiply-accumulate pass the product register, then the hi/lo update;
// divide loads the shared radix-2 divider (one quotient bit a cycle), then
// fixes signs; divide by zero and signed overflow skip it. The front keeps
// accepting into its two-entry queue, if it has room, while the back works.
module mips_integer_alu_execute_core (
   input logic      clock,
   input logic      reset,
   miae_req_if.sink req,
   miae_rsp_if.source rsp
);
   import miae_pkg::*;

   logic   push, full, pop, nempty;
   op_type push_data, pop_data;

   miae_front u_front (
      .in_valid (req.valid),
      .in_ready (req.ready),
      .in_data  (req.payload),
      .q_push   (push),
      .q_data   (push_data),
      .q_full   (full)
   );

   miae_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .not_empty (nempty),
      .pop_data  (pop_data)
   );

   miae_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (nempty),
      .q_data    (pop_data),
      .q_pop     (pop),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_data  (rsp.payload)
   );

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> nempty) else $error("pop from empty queue");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("push into full queue");
   a_no_r0_write: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.payload.write_enable |-> rsp.payload.dest_reg != 5'd0)
      else $error("write to register zero");
   a_bad_no_write: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.payload.unsupported |-> !rsp.payload.write_enable)
      else $error("unsupported op writes");

endmodule

>>> src/miae_front.sv
// ----------------------------------------------------------------------------
// miae_front
// decodes a beat and computes every result that needs no hi/lo state
// ----------------------------------------------------------------------------
module miae_front (
   input  logic              in_valid,
   output logic              in_ready,
   input  miae_pkg::req_type in_data,
   output logic              q_push,
   output miae_pkg::op_type  q_data,
   input  logic              q_full
);
   import miae_pkg::*;

   logic [5:0]  opc, fn;
   logic [4:0]  rs, rt, rd, sa, sh;
   logic [31:0] a, b, uimm, simm, mask, sm, val;
   logic        wr, bad, lts, ltu;
   op_type      o;

   assign in_ready = !q_full;
   assign q_push   = in_valid && !q_full;
   assign q_data   = o;

   always_comb begin
      opc  = in_data.instruction[31:26];
      rs   = in_data.instruction[25:21];
      rt   = in_data.instruction[20:16];
      rd   = in_data.instruction[15:11];
      sa   = in_data.instruction[10:6];
      fn   = in_data.instruction[5:0];
      a    = in_data.rs_value;
      b    = in_data.rt_value;
      sh   = a[4:0];
      uimm = {16'd0, in_data.instruction[15:0]};
      simm = {{16{in_data.instruction[15]}}, in_data.instruction[15:0]};
      mask = 32'hffffffff >> (5'd31 - rd);
      sm   = mask >> sa;
      lts  = 1'b0;
      ltu  = 1'b0;
      wr   = 1'b1;
      bad  = 1'b0;
      val  = '0;
      o    = '0;
      o.kind = K_SIMPLE;
      o.a    = a;
      o.b    = b;
      o.dst  = rd;
      if (opc == OP_SPECIAL) begin
         lts = $signed(a) < $signed(b);
         ltu = a < b;
         case (fn)
            FN_SLL:  val = b << sa;
            FN_SRL:  val = (rs == ROT_SEL) ? rot_r(b, sa) : (b >> sa);
            FN_SRA:  val = 32'($signed(b) >>> sa);
            FN_SLLV: val = b << sh;
            FN_SRLV: val = (sa == ROT_SEL) ? rot_r(b, sh) : (b >> sh);
            FN_SRAV: val = 32'($signed(b) >>> sh);
            FN_MOVZ: begin val = a; wr = (b == '0); end
            FN_MOVN: begin val = a; wr = (b != '0); end
            FN_MFHI: o.kind = K_MFHI;
            FN_MFLO: o.kind = K_MFLO;
            FN_MTHI: begin o.kind = K_MTHI; wr = 1'b0; end
            FN_MTLO: begin o.kind = K_MTLO; wr = 1'b0; end
            FN_CLZ:  val = lead_zeros(a);
            FN_CLO:  val = lead_zeros(~a);
            FN_MULT, FN_MULTU, FN_MADD, FN_MADDU, FN_MSUB, FN_MSUBU: begin
               o.kind = K_MUL;
               wr     = 1'b0;
               o.sgn  = (fn == FN_MULT) || (fn == FN_MADD) || (fn == FN_MSUB);
               o.acc  = (fn != FN_MULT) && (fn != FN_MULTU);
               o.sub  = (fn == FN_MSUB) || (fn == FN_MSUBU);
            end
            FN_DIV, FN_DIVU: begin
               o.kind = K_DIV;
               wr     = 1'b0;
               o.sgn  = (fn == FN_DIV);
            end
            FN_ADD, FN_ADDU: val = a + b;
            FN_SUB, FN_SUBU: val = a - b;
            FN_AND:  val = a & b;
            FN_OR:   val = a | b;
            FN_XOR:  val = a ^ b;
            FN_NOR:  val = ~(a | b);
            FN_SLT:  val = {31'd0, lts};
            FN_SLTU: val = {31'd0, ltu};
            FN_MAX:  val = lts ? b : a;
            FN_MIN:  val = ($signed(b) < $signed(a)) ? b : a;
            default: begin bad = 1'b1; wr = 1'b0; end
         endcase
      end else if (opc inside {[OP_ADDI:OP_LUI]}) begin
         o.dst = rt;
         case (opc)
            OP_ADDI, OP_ADDIU: val = a + simm;
            OP_SLTI:  val = {31'd0, $signed(a) < $signed(simm)};
            OP_SLTIU: val = {31'd0, a < simm};
            OP_ANDI:  val = a & uimm;
            OP_ORI:   val = a | uimm;
            OP_XORI:  val = a ^ uimm;
            default:  val = uimm << 16;
         endcase
      end else if (opc == OP_SPECIAL3) begin
         if (fn == FN3_EXT) begin
            o.dst = rt;
            val   = (a >> sa) & mask;
         end else if (fn == FN3_INS) begin
            o.dst = rt;
            val   = (b & ~(sm << sa)) | ((a & sm) << sa);
         end else if (fn == FN3_BSHFL) begin
            case (sa)
               SEL_WSBH:   val = {b[23:16], b[31:24], b[7:0], b[15:8]};
               SEL_WSBW:   val = {b[7:0], b[15:8], b[23:16], b[31:24]};
               SEL_SEB:    val = {{24{b[7]}}, b[7:0]};
               SEL_BITREV: val = {<<{b}};
               SEL_SEH:    val = {{16{b[15]}}, b[15:0]};
               default: begin bad = 1'b1; wr = 1'b0; end
            endcase
         end else begin
            bad = 1'b1;
            wr  = 1'b0;
         end
      end else begin
         bad = 1'b1;
         wr  = 1'b0;
      end
      if (o.dst == 5'd0 || bad) wr = 1'b0;
      if (bad) o.dst = 5'd0;
      o.wr  = wr;
      o.bad = bad;
      o.val = val;
   end

endmodule

>>> src/miae_queue.sv
// ----------------------------------------------------------------------------
// miae_queue
// two-entry fifo between the decode front and the execute back
// ----------------------------------------------------------------------------
module miae_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  miae_pkg::op_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output miae_pkg::op_type pop_data
);
   import miae_pkg::*;

   op_type     mem_ff [QDEPTH];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full      = (cnt_ff == 2'(QDEPTH));
   assign not_empty = (cnt_ff != 2'd0);
   assign pop_data  = mem_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff + 1'(push);
      rp_in  = rp_ff + 1'(pop);
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= push_data;
   end

endmodule

>>> src/miae_back.sv
// ----------------------------------------------------------------------------
// miae_back
// hi/lo owner: moves, multiply-accumulate, radix-2 divider
// ----------------------------------------------------------------------------
module miae_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  miae_pkg::op_type  q_data,
   output logic              q_pop,
   output logic              out_valid,
   input  logic              out_ready,
   output miae_pkg::rsp_type out_data
);
   import miae_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_MUL  = 2'd1;
   localparam logic [1:0] S_DIV  = 2'd2;
   localparam logic [1:0] S_FIN  = 2'd3;

   logic [1:0]  st_ff, st_in;
   logic [31:0] hi_ff, hi_in, lo_ff, lo_in;
   logic        ov_ff, ov_in;
   rsp_type     rsp_ff, rsp_in;
   op_type      cur_ff, cur_in;
   logic [63:0] prod_ff, prod_in, accv;
   logic [31:0] rem_ff, rem_in, quo_ff, quo_in, dvs_ff, dvs_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [32:0] trial;
   logic [31:0] ua, ub, qf, rf;
   logic        slot_free;

   assign out_valid = ov_ff;
   assign out_data  = rsp_ff;
   assign slot_free = !ov_ff || out_ready;

   always_comb begin
      st_in   = st_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      ov_in   = ov_ff && !out_ready;
      rsp_in  = rsp_ff;
      cur_in  = cur_ff;
      prod_in = prod_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      q_pop   = 1'b0;
      ua      = (q_data.sgn && q_data.a[31]) ? -q_data.a : q_data.a;
      ub      = (q_data.sgn && q_data.b[31]) ? -q_data.b : q_data.b;
      trial   = {rem_ff, quo_ff[31]} - {1'b0, dvs_ff};
      accv    = cur_ff.sub ? ({hi_ff, lo_ff} - prod_ff) : ({hi_ff, lo_ff} + prod_ff);
      qf      = (cur_ff.a[31] ^ cur_ff.b[31]) && cur_ff.sgn ? -quo_ff : quo_ff;
      rf      = (cur_ff.a[31] && cur_ff.sgn) ? -rem_ff : rem_ff;
      case (st_ff)
         S_IDLE: begin
            if (q_valid && slot_free) begin
               q_pop  = 1'b1;
               cur_in = q_data;
               rsp_in.write_enable = q_data.wr;
               rsp_in.dest_reg     = q_data.wr ? q_data.dst : 5'd0;
               rsp_in.dest_value   = q_data.wr ? q_data.val : 32'd0;
               rsp_in.unsupported  = q_data.bad;
               case (q_data.kind)
                  K_MFHI: if (q_data.wr) rsp_in.dest_value = hi_ff;
                  K_MFLO: if (q_data.wr) rsp_in.dest_value = lo_ff;
                  K_MTHI: hi_in = q_data.a;
                  K_MTLO: lo_in = q_data.a;
                  default: ;
               endcase
               if (q_data.kind == K_MUL) begin
                  prod_in = q_data.sgn
                     ? 64'($signed({{32{q_data.a[31]}}, q_data.a})
                           * $signed({{32{q_data.b[31]}}, q_data.b}))
                     : 64'({32'd0, q_data.a} * {32'd0, q_data.b});
                  st_in = S_MUL;
               end else if (q_data.kind == K_DIV) begin
                  if (q_data.b == '0) begin
                     hi_in = '0;
                     lo_in = '0;
                     rsp_in.hi_value = '0;
                     rsp_in.lo_value = '0;
                     ov_in = 1'b1;
                  end else if (q_data.sgn && q_data.a == 32'h80000000
                               && q_data.b == 32'hffffffff) begin
                     lo_in = 32'h80000000;
                     rsp_in.hi_value = hi_ff;
                     rsp_in.lo_value = 32'h80000000;
                     ov_in = 1'b1;
                  end else begin
                     rem_in = '0;
                     quo_in = ua;
                     dvs_in = ub;
                     cnt_in = 6'd32;
                     st_in  = S_DIV;
                  end
               end else begin
                  rsp_in.hi_value = (q_data.kind == K_MTHI) ? q_data.a : hi_ff;
                  rsp_in.lo_value = (q_data.kind == K_MTLO) ? q_data.a : lo_ff;
                  ov_in = 1'b1;
               end
            end
         end
         S_MUL: begin
            {hi_in, lo_in} = cur_ff.acc ? accv : prod_ff;
            rsp_in.hi_value = hi_in;
            rsp_in.lo_value = lo_in;
            ov_in = 1'b1;
            st_in = S_IDLE;
         end
         S_DIV: begin
            quo_in = {quo_ff[30:0], !trial[32]};
            rem_in = trial[32] ? {rem_ff[30:0], quo_ff[31]} : trial[31:0];
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) st_in = S_FIN;
         end
         default: begin
            hi_in = rf;
            lo_in = qf;
            rsp_in.hi_value = rf;
            rsp_in.lo_value = qf;
            ov_in = 1'b1;
            st_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         hi_ff <= '0;
         lo_ff <= '0;
         ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         hi_ff <= hi_in;
         lo_ff <= lo_in;
         ov_ff <= ov_in;
      end
      rsp_ff  <= rsp_in;
      cur_ff  <= cur_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
      cnt_ff  <= cnt_in;
   end

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the integer execute unit: a driver fed from a queue
// of instruction beats, a predictor of write-back and hi/lo, and a monitor
// that compares every response beat field by field with the oldest prediction
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import miae_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #2 clock = ~clock;

   miae_req_if req_ch ();
   miae_rsp_if rsp_ch ();

   mips_integer_alu_execute_core uut (
      .clock(clock), .reset(reset), .req(req_ch.sink), .rsp(rsp_ch.source)
   );

   req_type pending_q[$];
   int      pause_q[$];    // -1: wait until every prediction has been met
   rsp_type wb_q[$];
   logic [31:0] hi_model, lo_model;
   int  errors = 0;
   int  hold_len = 0;
   int  send_wait = 0, recv_wait = 0;
   bit  offering = 1'b0;

   function automatic logic signed [63:0] sx(input logic [31:0] x);
      return {{32{x[31]}}, x};
   endfunction

   function automatic logic [31:0] clz_of(input logic [31:0] x);
      int n;
      n = 0;
      for (int i = 31; i >= 0; i--) begin
         if (x[i]) break;
         n++;
      end
      return 32'(n);
   endfunction

   function automatic logic [31:0] rotate_right(input logic [31:0] x, input logic [4:0] s);
      logic [63:0] d;
      d = {x, x} >> s;
      return d[31:0];
   endfunction

   function automatic logic [31:0] bit_reverse(input logic [31:0] x);
      logic [31:0] r;
      for (int i = 0; i < 32; i++) r[i] = x[31-i];
      return r;
   endfunction

   function automatic bit less_s(input logic [31:0] a, input logic [31:0] b);
      return $signed(a) < $signed(b);
   endfunction

   function automatic rsp_type predict_writeback(input req_type it);
      rsp_type r;
      logic [5:0]  opc, fn;
      logic [4:0]  rs, rt, rd, sa, sh;
      logic [31:0] a, b, simm, uimm, val, mask, sm;
      logic [31:0] ua, ub, q, rm;
      logic [63:0] p, acc;
      logic [4:0]  dst;
      bit wr, bad;
      opc = it.instruction[31:26]; rs = it.instruction[25:21];
      rt = it.instruction[20:16]; rd = it.instruction[15:11];
      sa = it.instruction[10:6]; fn = it.instruction[5:0];
      uimm = {16'd0, it.instruction[15:0]};
      simm = {{16{it.instruction[15]}}, it.instruction[15:0]};
      a = it.rs_value; b = it.rt_value; sh = a[4:0];
      wr = 1'b0; bad = 1'b0; dst = 5'd0; val = 32'd0;
      if (opc == OP_SPECIAL) begin
         dst = rd; wr = 1'b1;
         case (fn)
            FN_SLL: val = b << sa;
            FN_SRL: val = (rs == ROT_SEL) ? rotate_right(b, sa) : b >> sa;
            FN_SRA: val = $signed(b) >>> sa;
            FN_SLLV: val = b << sh;
            FN_SRLV: val = (sa == ROT_SEL) ? rotate_right(b, sh) : b >> sh;
            FN_SRAV: val = $signed(b) >>> sh;
            FN_MOVZ: begin val = a; wr = (b == 0); end
            FN_MOVN: begin val = a; wr = (b != 0); end
            FN_MFHI: val = hi_model;
            FN_MTHI: begin hi_model = a; wr = 1'b0; end
            FN_MFLO: val = lo_model;
            FN_MTLO: begin lo_model = a; wr = 1'b0; end
            FN_CLZ: val = clz_of(a);
            FN_CLO: val = clz_of(~a);
            FN_MULT, FN_MULTU: begin
               p = (fn == FN_MULT) ? 64'(sx(a) * sx(b)) : {32'd0, a} * {32'd0, b};
               {hi_model, lo_model} = p; wr = 1'b0;
            end
            FN_DIV: begin
               wr = 1'b0;
               if (b == 0) begin hi_model = 0; lo_model = 0; end
               else if (a == 32'h8000_0000 && b == 32'hffff_ffff) lo_model = 32'h8000_0000;
               else begin
                  ua = a[31] ? -a : a; ub = b[31] ? -b : b;
                  q = ua / ub; rm = ua % ub;
                  if (a[31] ^ b[31]) q = -q;
                  if (a[31]) rm = -rm;
                  lo_model = q; hi_model = rm;
               end
            end
            FN_DIVU: begin
               wr = 1'b0;
               if (b == 0) begin hi_model = 0; lo_model = 0; end
               else begin lo_model = a / b; hi_model = a % b; end
            end
            FN_MADD, FN_MADDU, FN_MSUB, FN_MSUBU: begin
               p = (fn == FN_MADD || fn == FN_MSUB) ? 64'(sx(a) * sx(b))
                                                   : {32'd0, a} * {32'd0, b};
               acc = {hi_model, lo_model};
               acc = (fn == FN_MSUB || fn == FN_MSUBU) ? acc - p : acc + p;
               {hi_model, lo_model} = acc; wr = 1'b0;
            end
            FN_ADD, FN_ADDU: val = a + b;
            FN_SUB, FN_SUBU: val = a - b;
            FN_AND: val = a & b;
            FN_OR: val = a | b;
            FN_XOR: val = a ^ b;
            FN_NOR: val = ~(a | b);
            FN_SLT: val = {31'd0, less_s(a, b)};
            FN_SLTU: val = {31'd0, a < b};
            FN_MAX: val = less_s(a, b) ? b : a;
            FN_MIN: val = less_s(b, a) ? b : a;
            default: begin bad = 1'b1; wr = 1'b0; end
         endcase
      end else if (opc >= OP_ADDI && opc <= OP_LUI) begin
         dst = rt; wr = 1'b1;
         case (opc)
            OP_ADDI, OP_ADDIU: val = a + simm;
            OP_SLTI: val = {31'd0, less_s(a, simm)};
            OP_SLTIU: val = {31'd0, a < simm};
            OP_ANDI: val = a & uimm;
            OP_ORI: val = a | uimm;
            OP_XORI: val = a ^ uimm;
            default: val = uimm << 16;
         endcase
      end else if (opc == OP_SPECIAL3) begin
         mask = 32'hffff_ffff >> (5'd31 - rd);
         wr = 1'b1;
         if (fn == FN3_EXT) begin
            dst = rt; val = (a >> sa) & mask;
         end else if (fn == FN3_INS) begin
            sm = mask >> sa; dst = rt;
            val = (b & ~(sm << sa)) | ((a & sm) << sa);
         end else if (fn == FN3_BSHFL) begin
            dst = rd;
            case (sa)
               SEL_WSBH: val = {b[23:16], b[31:24], b[7:0], b[15:8]};
               SEL_WSBW: val = {b[7:0], b[15:8], b[23:16], b[31:24]};
               SEL_SEB: val = {{24{b[7]}}, b[7:0]};
               SEL_BITREV: val = bit_reverse(b);
               SEL_SEH: val = {{16{b[15]}}, b[15:0]};
               default: begin bad = 1'b1; wr = 1'b0; end
            endcase
         end else begin
            bad = 1'b1; wr = 1'b0;
         end
      end else begin
         bad = 1'b1;
      end
      if (dst == 0) wr = 1'b0;
      if (!wr) begin dst = 0; val = 0; end
      r.write_enable = wr; r.dest_reg = dst; r.dest_value = val;
      r.unsupported = bad; r.hi_value = hi_model; r.lo_value = lo_model;
      return r;
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 32'd0;
         1: return 32'hffff_ffff;
         2: return 32'h8000_0000;
         3: return 32'h7fff_ffff;
         4: return $urandom_range(0, 40);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_instruction();
      logic [31:0] w;
      logic [5:0] fns[33] = '{FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV,
         FN_MOVZ, FN_MOVN, FN_MFHI, FN_MTHI, FN_MFLO, FN_MTLO, FN_CLZ, FN_CLO,
         FN_MULT, FN_MULTU, FN_DIV, FN_DIVU, FN_MADD, FN_MADDU, FN_MSUB, FN_MSUBU,
         FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_AND, FN_OR, FN_XOR, FN_NOR,
         FN_SLT, FN_SLTU, FN_MAX};
      logic [4:0] sels[6] = '{SEL_WSBH, SEL_WSBW, SEL_SEB, SEL_BITREV, SEL_SEH, 5'd0};
      w = $urandom;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            w[31:26] = OP_SPECIAL;
            w[5:0] = ($urandom_range(0, 32) == 0) ? FN_MIN : fns[$urandom_range(0, 32)];
            if ($urandom_range(0, 2) == 0) w[25:21] = ROT_SEL;
            if ($urandom_range(0, 2) == 0) w[10:6] = ROT_SEL;
         end
         4, 5, 6: w[31:26] = OP_ADDI + 6'($urandom_range(0, 7));
         7, 8: begin
            w[31:26] = OP_SPECIAL3;
            case ($urandom_range(0, 2))
               0: w[5:0] = FN3_EXT;
               1: w[5:0] = FN3_INS;
               default: begin w[5:0] = FN3_BSHFL; w[10:6] = sels[$urandom_range(0, 5)]; end
            endcase
         end
         default: ;
      endcase
      return w;
   endfunction

   task automatic queue_beat(input logic [31:0] w, input logic [31:0] a,
                             input logic [31:0] b, input int gap);
      req_type it;
      it.instruction = w; it.rs_value = a; it.rt_value = b;
      pending_q.push_back(it);
      pause_q.push_back(gap);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.payload <= '0;
      end else begin
         if (offering && req_ch.ready) begin
            wb_q.push_back(predict_writeback(req_ch.payload));
            offering = 1'b0;
         end
         if (!offering) begin
            if (send_wait > 0) begin
               send_wait--;
               req_ch.valid <= 1'b0;
            end else if (pending_q.size() > 0 && pause_q[0] == -1 && wb_q.size() > 0) begin
               req_ch.valid <= 1'b0;
            end else if (pending_q.size() > 0) begin
               if (pause_q[0] == -1) void'(pause_q.pop_front());
               req_ch.payload <= pending_q.pop_front();
               send_wait = pause_q.pop_front();
               req_ch.valid <= 1'b1;
               offering = 1'b1;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type exp_r, got;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.payload;
            if (wb_q.size() == 0) begin
               $error("response beat with no prediction waiting");
               errors++;
            end else begin
               exp_r = wb_q.pop_front();
               if (got.write_enable !== exp_r.write_enable) begin
                  $error("write_enable exp %0h got %0h", exp_r.write_enable, got.write_enable);
                  errors++;
               end
               if (got.dest_reg !== exp_r.dest_reg) begin
                  $error("dest_reg exp %0h got %0h", exp_r.dest_reg, got.dest_reg);
                  errors++;
               end
               if (got.dest_value !== exp_r.dest_value) begin
                  $error("dest_value exp %0h got %0h", exp_r.dest_value, got.dest_value);
                  errors++;
               end
               if (got.unsupported !== exp_r.unsupported) begin
                  $error("unsupported exp %0h got %0h", exp_r.unsupported, got.unsupported);
                  errors++;
               end
               if (got.hi_value !== exp_r.hi_value) begin
                  $error("hi_value exp %0h got %0h", exp_r.hi_value, got.hi_value);
                  errors++;
               end
               if (got.lo_value !== exp_r.lo_value) begin
                  $error("lo_value exp %0h got %0h", exp_r.lo_value, got.lo_value);
                  errors++;
               end
            end
            recv_wait = (hold_len > 0) ? hold_len : $urandom_range(0, 9);
            if ($urandom_range(0, 3) == 0 && hold_len == 0) recv_wait = 0;
            hold_len = 0;
         end
         if (recv_wait > 0) begin
            recv_wait--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin
      logic [31:0] w;
      int gap;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready = 1'b0;
      hi_model = 32'd0;
      lo_model = 32'd0;
      // directed: extremes and special cases
      queue_beat({OP_SPECIAL, 5'd1, 5'd2, 5'd3, 5'd0, FN_SRL}, 0, 32'h1234_5678, 0);
      queue_beat({OP_SPECIAL, 5'd4, 5'd2, 5'd3, 5'd1, FN_SRLV}, 32'd0, 32'h8765_4321, 0);
      queue_beat({OP_SPECIAL, 5'd4, 5'd2, 5'd3, 5'd1, FN_SRLV}, 32'd37, 32'h8765_4321, 1);
      queue_beat({OP_SPECIAL, 5'd4, 5'd0, 5'd3, 5'd0, FN_CLZ}, 32'd0, 0, 0);
      queue_beat({OP_SPECIAL, 5'd4, 5'd0, 5'd3, 5'd0, FN_CLO}, 32'hffff_ffff, 0, 0);
      queue_beat({OP_SLTIU, 5'd1, 5'd2, 16'hffff}, 32'hffff_fffe, 0, 0);
      queue_beat({OP_SPECIAL, 5'd1, 5'd2, 5'd3, 5'd0, FN_DIV}, 32'd9, 32'd0, 0);
      queue_beat({OP_SPECIAL, 5'd1, 5'd2, 5'd3, 5'd0, FN_MTHI}, 32'h5a5a_5a5a, 0, 0);
      queue_beat({OP_SPECIAL, 5'd1, 5'd2, 5'd3, 5'd0, FN_DIV},
                 32'h8000_0000, 32'hffff_ffff, 0);
      queue_beat({OP_SPECIAL, 5'd1, 5'd2, 5'd3, 5'd0, FN_DIV}, 32'hffff_fff9, 32'd2, 2);
      queue_beat({OP_SPECIAL, 5'd1, 5'd2, 5'd3, 5'd0, FN_DIVU}, 32'hffff_ffff, 32'd7, 0);
      queue_beat({OP_SPECIAL, 5'd1, 5'd2, 5'd3, 5'd0, FN_MULT},
                 32'h8000_0000, 32'h8000_0000, 0);
      queue_beat({OP_SPECIAL, 5'd1, 5'd2, 5'd3, 5'd0, FN_MSUBU},
                 32'hffff_ffff, 32'hffff_ffff, 0);
      queue_beat({OP_SPECIAL, 5'd1, 5'd2, 5'd3, 5'd0, FN_MADD}, 32'hffff_ffff, 32'd3, 0);
      queue_beat({OP_SPECIAL, 5'd1, 5'd2, 5'd0, 5'd0, FN_ADDU}, 32'd1, 32'd2, 0);
      queue_beat({OP_SPECIAL, 5'd1, 5'd2, 5'd3, 5'd0, FN_MOVZ}, 32'd1, 32'd5, 0);
      queue_beat({OP_SPECIAL, 5'd1, 5'd2, 5'd3, 5'd0, 6'h01}, 32'd1, 32'd5, 0);
      queue_beat({6'h3f, 26'h3ff_ffff}, 32'hffff_ffff, 32'hffff_ffff, 0);
      queue_beat({OP_SPECIAL3, 5'd1, 5'd2, 5'd3, 5'd9, FN3_INS}, 32'hffff_ffff, 32'd0, 0);
      queue_beat({OP_SPECIAL3, 5'd1, 5'd2, 5'd31, 5'd0, FN3_EXT}, 32'h8000_0001, 0, 0);
      queue_beat({OP_SPECIAL3, 5'd1, 5'd2, 5'd3, SEL_BITREV, FN3_BSHFL}, 0, 32'h0000_0001, 0);
      queue_beat({OP_SPECIAL3, 5'd1, 5'd2, 5'd3, 5'd5, FN3_BSHFL}, 0, 32'h0000_0001, 0);
      queue_beat({OP_SPECIAL3, 5'd1, 5'd2, 5'd3, 5'd1, 6'h02}, 0, 32'h0000_0001, 0);
      // sender pause until every prediction has been met
      pause_q.push_back(-1);
      for (int i = 0; i < 1000; i++) begin
         w = pick_instruction();
         gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 9) : 0;
         if (i >= 400 && i < 500) gap = 0;
         if (i == 600) pause_q.push_back(-1);
         queue_beat(w, pick_value(), pick_value(), gap);
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      // long receiver hold-off while the sender keeps offering
      wait (pending_q.size() < 650);
      @(posedge clock);
      hold_len = 200;
      wait (pending_q.size() == 0 && !offering);
      wait (wb_q.size() == 0);
      repeat (50) @(posedge clock);
      if (errors == 0 && wb_q.size() == 0) begin
         $display("mips_integer_alu_execute_core: match");
      end else begin
         $display("mips_integer_alu_execute_core: mismatch");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("mips_integer_alu_execute_core: mismatch");
      $finish;
   end
endmodule
